// ===== rtl/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg
// types, widths and constants shared by the go-to-goal velocity law
// ----------------------------------------------------------------------------
package gtg_pkg;

  // lane widths
  localparam int PW = 31;           // position lane, signed
  localparam int QW = 36;           // quaternion lane, signed
  localparam int ZW = 34;           // angle accumulator, q.30 radians, signed
  localparam int AW = ZW - 18;      // angle rounded to q.12
  localparam int DW = 27;           // distance, q.12
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;

  // status codes
  localparam logic [1:0] ST_DRIVE    = 2'd0;
  localparam logic [1:0] ST_ROTATE   = 2'd1;
  localparam logic [1:0] ST_REACHED  = 2'd2;
  localparam logic [1:0] ST_CANCELED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DIST_TOL  = 3'd0;
  localparam logic [2:0] REG_HEAD_TOL  = 3'd1;
  localparam logic [2:0] REG_BEAR_GAIN = 3'd2;
  localparam logic [2:0] REG_DIST_GAIN = 3'd3;
  localparam logic [2:0] REG_YAW_GAIN  = 3'd4;
  localparam logic [2:0] REG_SPEED_LIM = 3'd5;

  typedef struct packed {
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               cancel;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        linear_speed;
    logic signed [31:0] turn_rate;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] distance_tolerance;
    logic [15:0] heading_tolerance;
    logic [15:0] bearing_gain;
    logic [15:0] distance_gain;
    logic [15:0] yaw_gain;
    logic [15:0] speed_limit;
  } cfg_t;

  // one cordic step for both lanes
  typedef struct packed {
    logic                 vld;
    logic                 cancel;
    logic                 pzero;
    logic                 qzero;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [ZW-1:0] pz;
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [ZW-1:0] qz;
  } cell_t;

  // arctangent table, q.30, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/gtg_cell.sv =====
// ----------------------------------------------------------------------------
// gtg_cell
// one cordic vectoring iteration on the position and quaternion lanes
// ----------------------------------------------------------------------------
module gtg_cell import gtg_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cell_t c_in,
  output cell_t c_out
);

  localparam logic signed [ZW-1:0] ANG = atan_q30(STAGE);

  cell_t c_r;
  cell_t c_nxt;

  always_comb begin
    c_nxt = c_in;
    // rotate toward the x axis, y == 0 counts as not positive
    if (c_in.py > 0) begin
      c_nxt.px = c_in.px + (c_in.py >>> STAGE);
      c_nxt.py = c_in.py - (c_in.px >>> STAGE);
      c_nxt.pz = c_in.pz + ANG;
    end else begin
      c_nxt.px = c_in.px - (c_in.py >>> STAGE);
      c_nxt.py = c_in.py + (c_in.px >>> STAGE);
      c_nxt.pz = c_in.pz - ANG;
    end
    if (c_in.qy > 0) begin
      c_nxt.qx = c_in.qx + (c_in.qy >>> STAGE);
      c_nxt.qy = c_in.qy - (c_in.qx >>> STAGE);
      c_nxt.qz = c_in.qz + ANG;
    end else begin
      c_nxt.qx = c_in.qx - (c_in.qy >>> STAGE);
      c_nxt.qy = c_in.qy + (c_in.qx >>> STAGE);
      c_nxt.qz = c_in.qz - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (adv) begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

// ===== rtl/gtg_regs.sv =====
// ----------------------------------------------------------------------------
// gtg_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module gtg_regs import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.distance_tolerance <= 16'd410;
      cfg_r.heading_tolerance  <= 16'd205;
      cfg_r.bearing_gain       <= 16'd6144;
      cfg_r.distance_gain      <= 16'd2048;
      cfg_r.yaw_gain           <= 16'd4096;
      cfg_r.speed_limit        <= 16'd2048;
    end else if (wr) begin
      case (paddr[4:2])
        REG_DIST_TOL:  cfg_r.distance_tolerance <= pwdata[15:0];
        REG_HEAD_TOL:  cfg_r.heading_tolerance  <= pwdata[15:0];
        REG_BEAR_GAIN: cfg_r.bearing_gain       <= pwdata[15:0];
        REG_DIST_GAIN: cfg_r.distance_gain      <= pwdata[15:0];
        REG_YAW_GAIN:  cfg_r.yaw_gain           <= pwdata[15:0];
        REG_SPEED_LIM: cfg_r.speed_limit        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DIST_TOL:  prdata = 32'(cfg_r.distance_tolerance);
      REG_HEAD_TOL:  prdata = 32'(cfg_r.heading_tolerance);
      REG_BEAR_GAIN: prdata = 32'(cfg_r.bearing_gain);
      REG_DIST_GAIN: prdata = 32'(cfg_r.distance_gain);
      REG_YAW_GAIN:  prdata = 32'(cfg_r.yaw_gain);
      REG_SPEED_LIM: prdata = 32'(cfg_r.speed_limit);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/go_to_goal_velocity_law.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_velocity_law
// fixed-point go-to-goal speed law for a unicycle robot
// ----------------------------------------------------------------------------
// one request per control tick: goal offset (q11.12), relative orientation
// quaternion (q1.14) and a cancel flag in, linear speed, turn rate and status
// out. the block is a straight pipeline that takes a new request every cycle
// while the output register is empty or taken; its stages are an input register
// with the quaternion products, a pre-rotation register, one register per cordic
// cell, three post stages (split 1/K multiply and angle rounding, distance sum
// and yaw magnitude, gain products) and the output register. the cordic row runs
// both vectors (position and planar quaternion) side by side in each cell.
// the whole pipeline moves when the output register is empty or taken; the
// first register also fills whenever it is empty. config registers sit
// behind the apb port at byte addresses 0x00..0x14 and are meant to be
// written only while the pipeline is empty
// ----------------------------------------------------------------------------
module go_to_goal_velocity_law import gtg_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN :
                        (CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES;

  cfg_t cfg;

  gtg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // global advance, plus fill of an empty first register
  logic adv;
  logic ld0;
  logic out_valid_r;
  logic s0_vld_r;

  assign adv      = out_ready || !out_valid_r;
  assign ld0      = adv || !s0_vld_r;
  assign in_ready = ld0;

  // ---- stage 0: scale position, quaternion products
  logic                 s0_cancel_r;
  logic signed [PW-1:0] s0_px_r, s0_py_r;
  logic signed [31:0]   s0_ww_r, s0_xx_r, s0_yy_r, s0_zz_r, s0_wz_r, s0_xy_r;
  logic signed [31:0]   qw32, qx32, qy32, qz32;

  assign qw32 = 32'(in_data.quat_w);
  assign qx32 = 32'(in_data.quat_x);
  assign qy32 = 32'(in_data.quat_y);
  assign qz32 = 32'(in_data.quat_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (ld0) begin
      s0_vld_r    <= in_valid;
      s0_cancel_r <= in_data.cancel;
      s0_px_r     <= PW'(in_data.offset_x) <<< 4;
      s0_py_r     <= PW'(in_data.offset_y) <<< 4;
      s0_ww_r     <= qw32 * qw32;
      s0_xx_r     <= qx32 * qx32;
      s0_yy_r     <= qy32 * qy32;
      s0_zz_r     <= qz32 * qz32;
      s0_wz_r     <= qw32 * qz32;
      s0_xy_r     <= qx32 * qy32;
    end
  end

  // ---- stage 1: yaw terms, zero vectors, pre-rotation into the right half
  logic signed [32:0] den;
  logic signed [33:0] num;
  logic signed [QW-1:0] qx0, qy0;
  cell_t s1_nxt, s1_r;

  assign den = 33'(s0_ww_r) + 33'(s0_xx_r) - 33'(s0_yy_r) - 33'(s0_zz_r);
  assign num = (34'(s0_wz_r) + 34'(s0_xy_r)) <<< 1;
  assign qx0 = QW'(den);
  assign qy0 = QW'(num);

  always_comb begin
    s1_nxt.vld    = s0_vld_r;
    s1_nxt.cancel = s0_cancel_r;
    s1_nxt.pzero  = (s0_px_r == '0) && (s0_py_r == '0);
    s1_nxt.qzero  = (qx0 == '0) && (qy0 == '0);
    s1_nxt.px = s0_px_r;
    s1_nxt.py = s0_py_r;
    s1_nxt.pz = '0;
    if (s0_px_r < 0) begin
      if (s0_py_r >= 0) begin
        s1_nxt.px = s0_py_r;
        s1_nxt.py = -s0_px_r;
        s1_nxt.pz = HALF_PI_Q30;
      end else begin
        s1_nxt.px = -s0_py_r;
        s1_nxt.py = s0_px_r;
        s1_nxt.pz = -HALF_PI_Q30;
      end
    end
    s1_nxt.qx = qx0;
    s1_nxt.qy = qy0;
    s1_nxt.qz = '0;
    if (qx0 < 0) begin
      if (qy0 >= 0) begin
        s1_nxt.qx = qy0;
        s1_nxt.qy = -qx0;
        s1_nxt.qz = HALF_PI_Q30;
      end else begin
        s1_nxt.qx = -qy0;
        s1_nxt.qy = qx0;
        s1_nxt.qz = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // ---- cordic row
  cell_t stg [0:NSTG];
  assign stg[0] = s1_r;

  for (genvar k = 0; k < NSTG; k++) begin : g_cell
    gtg_cell #(.STAGE(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .c_in  (stg[k]),
      .c_out (stg[k+1])
    );
  end

  cell_t c_end;
  assign c_end = stg[NSTG];

  // ---- post 1: split magnitude times 1/K, clamp and round angles
  logic [PW-2:0]        mag;
  logic signed [ZW-1:0] bz_cl, yz_cl, bz_rnd, yz_rnd;
  logic                 p1_vld_r, p1_cancel_r;
  logic [44:0]          p1_lo_r, p1_hi_r;
  logic signed [AW-1:0] p1_bear_r, p1_yaw_r;

  assign mag = c_end.px[PW-2:0];

  always_comb begin
    bz_cl = (c_end.pz > PI_Q30) ? PI_Q30 : (c_end.pz < -PI_Q30) ? -PI_Q30 : c_end.pz;
    yz_cl = (c_end.qz > PI_Q30) ? PI_Q30 : (c_end.qz < -PI_Q30) ? -PI_Q30 : c_end.qz;
    if (c_end.pzero) bz_cl = '0;
    if (c_end.qzero) yz_cl = '0;
    bz_rnd = bz_cl + (ZW'(1) <<< 17);
    yz_rnd = yz_cl + (ZW'(1) <<< 17);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r    <= c_end.vld;
      p1_cancel_r <= c_end.cancel;
      p1_lo_r     <= 45'(mag[14:0]) * 45'(INV_GAIN_Q30);
      p1_hi_r     <= 45'(mag[29:15]) * 45'(INV_GAIN_Q30);
      p1_bear_r   <= bz_rnd[ZW-1:18];
      p1_yaw_r    <= yz_rnd[ZW-1:18];
    end
  end

  // ---- post 2: distance, yaw magnitude
  logic [60:0]          dsum;
  logic [AW-1:0]        ayaw;
  logic                 p2_vld_r, p2_cancel_r, p2_turn_r;
  logic [DW-1:0]        p2_dist_r;
  logic signed [AW-1:0] p2_bear_r, p2_yaw_r;

  assign dsum = 61'(p1_lo_r) + (61'(p1_hi_r) << 15) + (61'(1) << 33);
  assign ayaw = p1_yaw_r[AW-1] ? AW'(-p1_yaw_r) : AW'(p1_yaw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r    <= p1_vld_r;
      p2_cancel_r <= p1_cancel_r;
      p2_dist_r   <= dsum[60:34];
      p2_turn_r   <= ayaw > cfg.heading_tolerance;
      p2_bear_r   <= p1_bear_r;
      p2_yaw_r    <= p1_yaw_r;
    end
  end

  // ---- post 3: gain products, mode decision
  logic               p3_vld_r, p3_cancel_r, p3_turn_r, p3_far_r;
  logic [42:0]        p3_lin_r;
  logic signed [32:0] p3_bt_r, p3_yt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r    <= p2_vld_r;
      p3_cancel_r <= p2_cancel_r;
      p3_turn_r   <= p2_turn_r;
      p3_far_r    <= p2_dist_r > DW'(cfg.distance_tolerance);
      p3_lin_r    <= 43'(p2_dist_r) * 43'(cfg.distance_gain);
      p3_bt_r     <= $signed({17'b0, cfg.bearing_gain}) * 33'(p2_bear_r);
      p3_yt_r     <= $signed({17'b0, cfg.yaw_gain}) * 33'(p2_yaw_r);
    end
  end

  // ---- output register: round, clamp, select
  logic [43:0]        lin_sum;
  logic [15:0]        lin_sat;
  logic signed [33:0] bt_sum, yt_sum;
  out_item_t          out_nxt, out_data_r;

  assign lin_sum = 44'(p3_lin_r) + 44'd2048;
  assign lin_sat = (lin_sum[43:12] > 32'(cfg.speed_limit)) ? cfg.speed_limit
                                                           : lin_sum[27:12];
  assign bt_sum  = 34'(p3_bt_r) + 34'sd2048;
  assign yt_sum  = 34'(p3_yt_r) + 34'sd2048;

  always_comb begin
    out_nxt.linear_speed = '0;
    out_nxt.turn_rate    = '0;
    if (p3_cancel_r) begin
      out_nxt.status = ST_CANCELED;
    end else if (p3_far_r) begin
      out_nxt.status       = ST_DRIVE;
      out_nxt.linear_speed = lin_sat;
      out_nxt.turn_rate    = 32'($signed(bt_sum[33:12]));
    end else if (p3_turn_r) begin
      out_nxt.status    = ST_ROTATE;
      out_nxt.turn_rate = 32'($signed(yt_sum[33:12]));
    end else begin
      out_nxt.status = ST_REACHED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= p3_vld_r;
      out_data_r  <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // cancel and reached always command standstill
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_CANCELED || out_data_r.status == ST_REACHED)
    |-> out_data_r.linear_speed == '0 && out_data_r.turn_rate == '0)
    else $error("stop status with nonzero command");

  // rotating in place never moves forward
  a_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_ROTATE |-> out_data_r.linear_speed == '0)
    else $error("rotate status with forward speed");

  // forward speed stays within the limit
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.linear_speed <= cfg.speed_limit)
    else $error("linear speed above limit");
`endif

endmodule
